[rtl/keyframe_bezier_curve_eval_unit_defines.svh]
// Assertion macros for the keyframe curve unit.
// Included by the RTL files that carry assertions; needs nothing else.
`ifndef KEYFRAME_BEZIER_CURVE_EVAL_UNIT_DEFINES_SVH
`define KEYFRAME_BEZIER_CURVE_EVAL_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KBC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KBC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/kbc_pkg.sv]
// Shared types and constants for the keyframe curve unit.
// No dependencies.
package kbc_pkg;
    localparam int MAX_KEYS_DEF   = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int U_BITS         = 17;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_EVAL   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADIX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_SCAN, S_INS_SHIFT, S_INS_PUT, S_REM_SHIFT,
        S_EV_SCAN, S_EV_LOAD, S_EV_DIV, S_EV_LERP, S_DONE
    } t_state;

    // Lerp unit request.
    typedef struct packed {
        logic start;
    } t_lerp_ctl;
endpackage

[rtl/keyframe_bezier_curve_eval_unit.sv]
// Top level of the keyframe Bezier curve unit: key table and sequencer.
// Depends on kbc_pkg, kbc_lerp and the defines header.
//
// One command is taken while busy is low; its single result appears with
// o_done high for one cycle, in the cycle that busy drops, and cannot be
// stalled. Clear, a dropped insert, a bad remove index and an evaluate on
// an empty table go straight to the result. Insert scans the table one key
// a cycle and then shifts one key a cycle. Remove shifts one key a cycle.
// Evaluate scans segments one a cycle, loads the points, runs a restoring
// divider for u and then up to six x/y lerp pairs through one shared lerp unit.
`include "keyframe_bezier_curve_eval_unit_defines.svh"
module keyframe_bezier_curve_eval_unit #(
    parameter int MAX_KEYS   = kbc_pkg::MAX_KEYS_DEF,
    parameter int COORD_BITS = kbc_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_key_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_left_x,
    input  logic signed [31:0] i_left_y,
    input  logic signed [31:0] i_right_x,
    input  logic signed [31:0] i_right_y,
    input  logic        i_has_left,
    input  logic        i_has_right,
    input  logic signed [31:0] i_query_time,
    output logic        o_done,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [1:0]  o_status,
    output logic [4:0]  o_keys_held
);
    import kbc_pkg::*;
    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int CB = COORD_BITS;

    typedef logic signed [CB-1:0] t_c;

    // Key table, one entry per key, flags bit 0 left, bit 1 right.
    t_c         r_px [MAX_KEYS];
    t_c         r_py [MAX_KEYS];
    t_c         r_lx [MAX_KEYS];
    t_c         r_ly [MAX_KEYS];
    t_c         r_rx [MAX_KEYS];
    t_c         r_ry [MAX_KEYS];
    logic [1:0] r_fl [MAX_KEYS];

    t_state     r_state, n_state;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_pos;
    t_c         r_nx, r_ny, r_nlx, r_nly, r_nrx, r_nry, r_t;
    logic [1:0] r_nfl;
    t_c         r_xs [4];
    t_c         r_ys [4];
    logic [2:0] r_n;
    logic [2:0] r_lvl;
    logic [1:0] r_li;
    logic       r_ly_ph;
    logic [CB:0] r_num, r_den;
    logic [4:0] r_dstep;
    logic [U_BITS-1:0] r_u;
    logic signed [31:0] r_ox, r_oy;
    logic [1:0] r_st;
    logic       r_done;

    logic [IW-1:0] w_i, w_i1;
    t_c         w_x1, w_x2;
    logic       w_in_seg, w_last_seg;
    logic [CB:0] w_num2;
    t_lerp_ctl  w_lctl;
    t_c         w_la, w_lb, w_lr;
    logic       w_ldone;

    assign w_i      = r_i[IW-1:0];
    assign w_i1     = IW'(r_i + CW'(1));
    assign w_x1     = r_px[w_i];
    assign w_x2     = r_px[w_i1];
    assign w_in_seg = (r_t >= w_x1) && (r_t <= w_x2);
    assign w_last_seg = (r_i + CW'(2) >= r_total);
    assign w_num2   = {r_num[CB-1:0], 1'b0};

    // Shared lerp unit; x then y of the current pair.
    assign w_la = r_ly_ph ? r_ys[r_li] : r_xs[r_li];
    assign w_lb = r_ly_ph ? r_ys[2'(r_li + 2'd1)] : r_xs[2'(r_li + 2'd1)];

    kbc_lerp #(.COORD_BITS(CB)) u_lerp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_lctl),
        .i_a    (w_la),
        .i_b    (w_lb),
        .i_u    (r_u),
        .o_r    (w_lr),
        .o_done (w_ldone)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_action)
                        ACT_CLEAR:  n_state = S_DONE;
                        ACT_INSERT: n_state = (CW'(MAX_KEYS) <= r_total) ? S_DONE
                                                                      : S_INS_SCAN;
                        ACT_REMOVE: n_state = (CW'(i_key_index) >= r_total ||
                                               32'(i_key_index) >= MAX_KEYS)
                                              ? S_DONE : S_REM_SHIFT;
                        default:    n_state = (r_total == '0) ? S_DONE : S_EV_SCAN;
                    endcase
                end
            end
            S_INS_SCAN:  if (r_i >= r_total || r_px[w_i] > r_nx) n_state = S_INS_SHIFT;
            S_INS_SHIFT: if (r_i <= CW'(r_pos)) n_state = S_INS_PUT;
            S_INS_PUT:   n_state = S_DONE;
            S_REM_SHIFT: if (r_i + CW'(1) >= r_total) n_state = S_DONE;
            S_EV_SCAN: begin
                if (r_i + CW'(1) >= r_total) n_state = S_DONE;
                else if (w_in_seg) n_state = S_EV_LOAD;
                else if (w_last_seg) n_state = S_DONE;
            end
            S_EV_LOAD:   n_state = S_EV_DIV;
            S_EV_DIV:    if (r_dstep == 5'd17) n_state = S_EV_LERP;
            S_EV_LERP:   if (r_lvl <= 3'd1) n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer; a lerp starts once the previous result is stored.
    always_comb begin
        busy        = (r_state != S_IDLE);
        w_lctl.start = (r_state == S_EV_LERP) && (r_lvl > 3'd1) && (r_dstep == 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Key count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            if (r_state == S_IDLE && start && i_action == ACT_CLEAR) r_total <= '0;
            if (r_state == S_INS_PUT) r_total <= r_total + CW'(1);
            if (r_state == S_REM_SHIFT && n_state == S_DONE) r_total <= r_total - CW'(1);
        end
    end

    // Datapath and table moves.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_nx <= t_c'(i_pos_x);   r_ny <= t_c'(i_pos_y);
                r_nlx <= t_c'(i_left_x); r_nly <= t_c'(i_left_y);
                r_nrx <= t_c'(i_right_x); r_nry <= t_c'(i_right_y);
                r_nfl <= {i_has_right, i_has_left};
                r_t <= t_c'(i_query_time);
                r_i <= (i_action == ACT_REMOVE) ? CW'(i_key_index) : '0;
                r_ox <= '0; r_oy <= '0;
                r_st <= ST_OK;
                if (start && i_action == ACT_INSERT && CW'(MAX_KEYS) <= r_total)
                    r_st <= ST_FULL;
                if (start && i_action == ACT_REMOVE && (CW'(i_key_index) >= r_total ||
                                                        32'(i_key_index) >= MAX_KEYS))
                    r_st <= ST_BADIX;
                if (start && i_action == ACT_EVAL && r_total == '0) r_st <= ST_EMPTY;
            end
            S_INS_SCAN: begin
                if (r_i >= r_total || r_px[w_i] > r_nx) begin
                    r_pos <= w_i;
                    r_i   <= r_total;
                end else r_i <= r_i + CW'(1);
            end
            S_INS_SHIFT: begin
                if (r_i > CW'(r_pos)) begin
                    r_px[w_i] <= r_px[IW'(r_i - CW'(1))];
                    r_py[w_i] <= r_py[IW'(r_i - CW'(1))];
                    r_lx[w_i] <= r_lx[IW'(r_i - CW'(1))];
                    r_ly[w_i] <= r_ly[IW'(r_i - CW'(1))];
                    r_rx[w_i] <= r_rx[IW'(r_i - CW'(1))];
                    r_ry[w_i] <= r_ry[IW'(r_i - CW'(1))];
                    r_fl[w_i] <= r_fl[IW'(r_i - CW'(1))];
                    r_i <= r_i - CW'(1);
                end
            end
            S_INS_PUT: begin
                r_px[r_pos] <= r_nx;  r_py[r_pos] <= r_ny;
                r_lx[r_pos] <= r_nlx; r_ly[r_pos] <= r_nly;
                r_rx[r_pos] <= r_nrx; r_ry[r_pos] <= r_nry;
                r_fl[r_pos] <= r_nfl;
            end
            S_REM_SHIFT: begin
                if (r_i + CW'(1) < r_total) begin
                    r_px[w_i] <= r_px[w_i1]; r_py[w_i] <= r_py[w_i1];
                    r_lx[w_i] <= r_lx[w_i1]; r_ly[w_i] <= r_ly[w_i1];
                    r_rx[w_i] <= r_rx[w_i1]; r_ry[w_i] <= r_ry[w_i1];
                    r_fl[w_i] <= r_fl[w_i1];
                end
                r_i <= r_i + CW'(1);
            end
            S_EV_SCAN: begin
                if (r_i + CW'(1) >= r_total || (!w_in_seg && w_last_seg)) begin
                    r_ox <= 32'(r_t);
                    r_oy <= 32'(r_py[IW'(r_total - CW'(1))]);
                end else if (!w_in_seg) r_i <= r_i + CW'(1);
            end
            S_EV_LOAD: begin
                // Control points in order, count by tangent flags.
                r_xs[0] <= r_px[w_i]; r_ys[0] <= r_py[w_i];
                unique case ({r_fl[w_i][1], r_fl[w_i1][0]})
                    2'b11: begin
                        r_xs[1] <= r_rx[w_i];  r_ys[1] <= r_ry[w_i];
                        r_xs[2] <= r_lx[w_i1]; r_ys[2] <= r_ly[w_i1];
                        r_xs[3] <= r_px[w_i1]; r_ys[3] <= r_py[w_i1];
                        r_n <= 3'd4;
                    end
                    2'b10: begin
                        r_xs[1] <= r_rx[w_i];  r_ys[1] <= r_ry[w_i];
                        r_xs[2] <= r_px[w_i1]; r_ys[2] <= r_py[w_i1];
                        r_n <= 3'd3;
                    end
                    2'b01: begin
                        r_xs[1] <= r_lx[w_i1]; r_ys[1] <= r_ly[w_i1];
                        r_xs[2] <= r_px[w_i1]; r_ys[2] <= r_py[w_i1];
                        r_n <= 3'd3;
                    end
                    default: begin
                        r_xs[1] <= r_px[w_i1]; r_ys[1] <= r_py[w_i1];
                        r_n <= 3'd2;
                    end
                endcase
                r_num   <= (CB+1)'(r_t) - (CB+1)'(w_x1);
                r_den   <= (CB+1)'(w_x2) - (CB+1)'(w_x1);
                r_dstep <= 5'd0;
                r_u     <= '0;
            end
            S_EV_DIV: begin
                // Restoring divider, one quotient bit a cycle.
                if (r_dstep == 5'd0) begin
                    if (r_den == '0) r_dstep <= 5'd17;
                    else if (r_num >= r_den) begin
                        r_u <= U_BITS'(65536); r_dstep <= 5'd17;
                    end else r_dstep <= 5'd1;
                end else if (r_dstep == 5'd17) begin
                    r_lvl <= r_n; r_li <= 2'd0; r_ly_ph <= 1'b0;
                    r_dstep <= 5'd0;
                end else begin
                    if (w_num2 >= r_den) begin
                        r_num <= w_num2 - r_den;
                        r_u   <= {r_u[U_BITS-2:0], 1'b1};
                    end else begin
                        r_num <= w_num2;
                        r_u   <= {r_u[U_BITS-2:0], 1'b0};
                    end
                    r_dstep <= r_dstep + 5'd1;
                end
            end
            S_EV_LERP: begin
                // r_dstep marks a lerp in flight.
                if (r_lvl <= 3'd1) begin
                    r_ox <= 32'(r_xs[0]); r_oy <= 32'(r_ys[0]);
                end else if (r_dstep == 5'd0) begin
                    r_dstep <= 5'd1;
                end else if (w_ldone) begin
                    if (r_ly_ph) r_ys[r_li] <= w_lr;
                    else         r_xs[r_li] <= w_lr;
                    r_dstep <= 5'd0;
                    if (!r_ly_ph) r_ly_ph <= 1'b1;
                    else begin
                        r_ly_ph <= 1'b0;
                        if (3'(r_li) + 3'd2 >= r_lvl) begin
                            r_li <= 2'd0; r_lvl <= r_lvl - 3'd1;
                        end else r_li <= r_li + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_done      = r_done;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_status    = r_st;
    assign o_keys_held = 5'(r_total);

    `KBC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_total <= CW'(MAX_KEYS))
    `KBC_ASSERT_NXT(a_done_after, i_clk, i_rst_n, r_state == S_DONE, o_done)
    `KBC_ASSERT_IMP(a_busy_done, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    `KBC_ASSERT_IMP(a_full_drop, i_clk, i_rst_n, o_done && o_status == ST_FULL,
                    r_total == CW'(MAX_KEYS))
endmodule

[rtl/kbc_lerp.sv]
// Iterative lerp unit: a + s*round(|b-a|*u/65536), two half multiplies.
// Depends on kbc_pkg.
module kbc_lerp #(
    parameter int COORD_BITS = kbc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kbc_pkg::t_lerp_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic [kbc_pkg::U_BITS-1:0]   i_u,
    output logic signed [COORD_BITS-1:0] o_r,
    output logic                         o_done
);
    import kbc_pkg::*;
    localparam int DW = COORD_BITS + 1;
    localparam int HW = DW - 16;

    logic [1:0]            r_ph;
    logic                  r_neg;
    logic [DW-1:0]         r_mag;
    logic signed [DW-1:0]  r_a;
    logic [DW+U_BITS-1:0]  r_p;
    logic [U_BITS-1:0]     r_u;
    logic signed [DW-1:0]  n_d;
    logic [HW+U_BITS-1:0]  n_hi;
    logic [16+U_BITS-1:0]  n_lo;
    logic signed [DW-1:0]  n_r;

    assign n_d  = DW'(i_b) - DW'(i_a);
    // High part accumulated in phase 1, rounded low part in phase 2.
    assign n_hi = r_mag[DW-1:16] * r_u;
    assign n_lo = r_mag[15:0] * r_u + (16+U_BITS)'(32768);
    assign n_r  = r_neg ? r_a - DW'(r_p) : r_a + DW'(r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
        end else if (i_ctl.start) begin
            r_ph <= 2'd1;
        end else if (r_ph != 2'd0) begin
            r_ph <= r_ph + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_neg <= n_d[DW-1];
            r_mag <= n_d[DW-1] ? DW'(-n_d) : DW'(n_d);
            r_a   <= DW'(i_a);
            r_u   <= i_u;
        end else if (r_ph == 2'd1) begin
            r_p <= (DW+U_BITS)'(n_hi);
        end else if (r_ph == 2'd2) begin
            r_p <= r_p + (DW+U_BITS)'(n_lo[16+U_BITS-1:16]);
        end
    end

    assign o_r    = n_r[COORD_BITS-1:0];
    assign o_done = (r_ph == 2'd3);
endmodule
